// File: src/sobel_edge_magnitude_stream_unit_assert.svh
// Assertion macros for the checker file, sem_checker.sv.
`ifndef SOBEL_EDGE_MAGNITUDE_STREAM_UNIT_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_STREAM_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SEM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SEM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/sem_pkg.sv
`default_nettype none

package sem_pkg;

  localparam int PIX_W          = 8;
  localparam int CFG_W          = 11;
  localparam int CFG_IDX_W      = 1;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int RESET_WIDTH    = 64;
  localparam int RESET_HEIGHT   = 64;
  localparam int WIN_N          = 9;
  localparam int GRAD_W         = 11;   // |Gx|, |Gy| <= 1020
  localparam int MAG_W          = 12;   // |Gx| + |Gy| <= 2040
  localparam int MAG_SHIFT      = 3;    // divide by 8
  localparam int PIX_MAX        = 255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } sem_reg_e;

  typedef logic [PIX_W-1:0] sem_pix_t;

  // 3x3 window, row-major: entry 0 is top-left, entry 8 bottom-right.
  typedef sem_pix_t [WIN_N-1:0] sem_win_t;

  typedef struct packed {
    logic valid;     // result belongs to a real pixel
    logic last;      // last pixel of a frame
    logic interior;  // pixel is off the frame border
  } sem_ctl_t;

endpackage

`default_nettype wire

// File: src/sem_edge_pipe.sv
`default_nettype none

// Gradient stage and magnitude/output stage with a stream output.
module sem_edge_pipe (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  sem_pkg::sem_ctl_t   ctl_i,
  input  sem_pkg::sem_win_t   win_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output sem_pkg::sem_pix_t   edge_o,
  output sem_pkg::sem_ctl_t   ctl_o
);

  localparam int GW = sem_pkg::GRAD_W;
  localparam int MW = sem_pkg::MAG_W;
  localparam int SW = MW - sem_pkg::MAG_SHIFT;

  logic                grd_vld_q;
  sem_pkg::sem_ctl_t   grd_ctl_q;
  logic signed [GW-1:0] gx_q, gx_d, gy_q, gy_d;

  logic                out_vld_q;
  sem_pkg::sem_ctl_t   out_ctl_q;
  sem_pkg::sem_pix_t   edge_q, edge_d;

  logic                grd_leave;
  logic                out_free;

  logic signed [GW-1:0] p00, p01, p02, p10, p12, p20, p21, p22;
  logic [GW-1:0]        abs_x, abs_y;
  logic [MW-1:0]        mag_sum;
  logic [SW-1:0]        mag_div;

  assign out_free   = !out_vld_q || out_ready_i;
  assign grd_leave  = grd_vld_q && out_free;
  assign in_ready_o = !grd_vld_q || grd_leave;

  always_comb begin
    p00 = signed'(GW'(win_i[0]));
    p01 = signed'(GW'(win_i[1]));
    p02 = signed'(GW'(win_i[2]));
    p10 = signed'(GW'(win_i[3]));
    p12 = signed'(GW'(win_i[5]));
    p20 = signed'(GW'(win_i[6]));
    p21 = signed'(GW'(win_i[7]));
    p22 = signed'(GW'(win_i[8]));
    gx_d = (p02 - p00) + ((p12 - p10) <<< 1) + (p22 - p20);
    gy_d = (p20 - p00) + ((p21 - p01) <<< 1) + (p22 - p02);
  end

  always_comb begin
    abs_x   = gx_q[GW-1] ? GW'(-gx_q) : GW'(gx_q);
    abs_y   = gy_q[GW-1] ? GW'(-gy_q) : GW'(gy_q);
    mag_sum = MW'(abs_x) + MW'(abs_y);
    mag_div = mag_sum[MW-1:sem_pkg::MAG_SHIFT];
    if (!grd_ctl_q.interior) begin
      edge_d = '0;
    end else if (mag_div > SW'(sem_pkg::PIX_MAX)) begin
      edge_d = sem_pkg::PIX_W'(sem_pkg::PIX_MAX);
    end else begin
      edge_d = mag_div[sem_pkg::PIX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grd_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        grd_vld_q <= in_valid_i;
      end
      if (out_free) begin
        out_vld_q <= grd_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      gx_q      <= gx_d;
      gy_q      <= gy_d;
      grd_ctl_q <= ctl_i;
    end
    if (grd_leave) begin
      edge_q    <= edge_d;
      out_ctl_q <= grd_ctl_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign edge_o      = edge_q;
  assign ctl_o       = out_ctl_q;

endmodule

`default_nettype wire

// File: src/sobel_edge_magnitude_stream_unit.sv
// 3x3 Sobel edge detector, L1 magnitude, streaming.
// Slave stream: one grey pixel per beat in raster order, frame after frame.
// Master stream: one result beat per input beat; tdata is the edge value
// (|Gx|+|Gy|)/8 clamped to 255, tuser marks a real pixel, tlast marks the
// last pixel of a frame. Each result belongs to the pixel width+1 raster
// positions before the current input; the first width+1 results after reset
// carry tuser = 0, tlast = 0 and tdata = 0. Border pixels give 0.
// Configuration: register 0 is the frame width, register 1 the frame height
// (0 acts as 1, values above the maximum act as the maximum). Write them only
// while the stream is idle; the config channel is always ready.
// Throughput: one pixel per clock while m_axis_tready stays high. Registers from
// the accepted input beat to the result beat: line store read, window, gradients,
// magnitude. Both line stores share one memory with a registered read port; a
// write in the same cycle as a read of the same column (width 1) is forwarded.
// Reset: position counters, start-up fill count and window clear, size
// registers go to 64x64, line stores keep whatever they hold (no clear pass).
// Stall: a held master beat keeps its payload; the pipeline keeps taking
// pixels until every stage is full, then s_axis_tready drops.
`default_nettype none

module sobel_edge_magnitude_stream_unit #(
  parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // Pixel input
  input  wire                          s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  wire  [sem_pkg::PIX_W-1:0]    s_axis_tdata_i,  // [7:0] pixel_in
  // Edge output
  output logic                         m_axis_tvalid_o,
  input  wire                          m_axis_tready_i,
  output logic [sem_pkg::PIX_W-1:0]    m_axis_tdata_o,  // [7:0] edge_out
  output logic                         m_axis_tuser_o,  // [0] out_valid
  output logic                         m_axis_tlast_o,  // frame_last
  // Configuration writes
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire  [sem_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire  [sem_pkg::CFG_W-1:0]    cfg_data_i
);

  localparam int PW  = sem_pkg::PIX_W;
  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int HA  = $clog2(MAX_HEIGHT);
  localparam int WC  = $clog2(MAX_WIDTH + 1);
  localparam int HC  = $clog2(MAX_HEIGHT + 1);
  localparam int WW  = (WC > sem_pkg::CFG_W) ? WC : sem_pkg::CFG_W;
  localparam int HW  = (HC > sem_pkg::CFG_W) ? HC : sem_pkg::CFG_W;
  localparam int FW  = WW + 1;
  localparam int LW  = 2 * PW;  // one word holds both line stores

  // Size registers
  logic [sem_pkg::CFG_W-1:0] frame_width_q, frame_height_q;

  // Effective sizes
  logic [WW-1:0] cfg_w_ext, eff_w;
  logic [HW-1:0] cfg_h_ext, eff_h;

  // Raster positions and start-up fill
  logic [AW-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [HA-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic [WW-1:0] in_col_inc, out_col_inc;
  logic [HW-1:0] in_row_inc, out_row_inc;
  logic [FW-1:0] fill_q, fill_d, fill_inc;
  logic          primed_q, primed_d;
  sem_pkg::sem_ctl_t acc_ctl;

  // Line store memory: [PW-1:0] previous row, [LW-1:PW] row before that
  logic [LW-1:0] line_mem [MAX_WIDTH];
  logic [LW-1:0] rd_q, fwd_word_q, cur_word, wr_word;
  logic          fwd_hit_q;

  // Stage 1: waiting for the line store read
  logic              s1_vld_q;
  sem_pkg::sem_pix_t s1_pix_q;
  logic [AW-1:0]     s1_col_q;
  sem_pkg::sem_ctl_t s1_ctl_q;

  // Stage 2: window holds this item's neighborhood
  logic              s2_vld_q;
  sem_pkg::sem_ctl_t s2_ctl_q;
  sem_pkg::sem_win_t win_q;

  logic s_acc, s1_leave, s2_leave, pipe_ready;
  sem_pkg::sem_pix_t above, above2;
  sem_pkg::sem_ctl_t out_ctl;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= sem_pkg::CFG_W'(sem_pkg::RESET_WIDTH);
      frame_height_q <= sem_pkg::CFG_W'(sem_pkg::RESET_HEIGHT);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (sem_pkg::sem_reg_e'(cfg_index_i))
        sem_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        sem_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Zero acts as one, oversize width clamps to the store depth, height to MAX_HEIGHT.
  always_comb begin
    cfg_w_ext = WW'(frame_width_q);
    cfg_h_ext = HW'(frame_height_q);
    if (cfg_w_ext == '0) begin
      eff_w = WW'(1);
    end else if (cfg_w_ext > WW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = cfg_w_ext;
    end
    if (cfg_h_ext == '0) begin
      eff_h = HW'(1);
    end else if (cfg_h_ext > HW'(MAX_HEIGHT)) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = cfg_h_ext;
    end
  end

  // Handshake chain: a stage moves when the next one is free or moving.
  assign s2_leave        = s2_vld_q && pipe_ready;
  assign s1_leave        = s1_vld_q && (!s2_vld_q || s2_leave);
  assign s_axis_tready_o = !s1_vld_q || s1_leave;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  // Position bookkeeping, resolved at accept time.
  always_comb begin
    in_col_inc = WW'(in_col_q) + WW'(1);
    in_row_inc = HW'(in_row_q) + HW'(1);
    in_col_d   = in_col_q + AW'(1);
    in_row_d   = in_row_q;
    if (in_col_inc >= eff_w) begin
      in_col_d = '0;
      in_row_d = (in_row_inc >= eff_h) ? '0 : in_row_inc[HA-1:0];
    end

    out_col_inc = WW'(out_col_q) + WW'(1);
    out_row_inc = HW'(out_row_q) + HW'(1);
    out_col_d   = out_col_q;
    out_row_d   = out_row_q;
    fill_inc    = fill_q + FW'(1);
    fill_d      = fill_q;
    primed_d    = primed_q;

    acc_ctl.valid    = primed_q;
    acc_ctl.interior = 1'b0;
    acc_ctl.last     = 1'b0;

    if (!primed_q) begin
      fill_d   = fill_inc;
      primed_d = (fill_inc >= FW'(eff_w) + FW'(1));
    end else begin
      acc_ctl.interior = (out_col_q != '0) && (out_col_inc < eff_w) &&
                         (out_row_q != '0) && (out_row_inc < eff_h);
      acc_ctl.last     = (WW'(out_col_q) == eff_w - WW'(1)) &&
                         (HW'(out_row_q) == eff_h - HW'(1));
      out_col_d = out_col_q + AW'(1);
      if (out_col_inc >= eff_w) begin
        out_col_d = '0;
        out_row_d = (out_row_inc >= eff_h) ? '0 : out_row_inc[HA-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      fill_q    <= '0;
      primed_q  <= 1'b0;
    end else if (s_acc) begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      fill_q    <= fill_d;
      primed_q  <= primed_d;
    end
  end

  // Take the write of the leaving item when it hits the column just read.
  assign cur_word = fwd_hit_q ? fwd_word_q : rd_q;
  assign above    = cur_word[PW-1:0];
  assign above2   = cur_word[LW-1:PW];
  assign wr_word  = {above, s1_pix_q};

  // Read on accept, write back when the item leaves stage 1.
  always_ff @(posedge clk_i) begin
    if (s1_leave) begin
      line_mem[s1_col_q] <= wr_word;
    end
    if (s_acc) begin
      rd_q       <= line_mem[in_col_q];
      fwd_hit_q  <= s1_leave && (s1_col_q == in_col_q);
      fwd_word_q <= wr_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      win_q    <= '0;
    end else begin
      if (s_axis_tready_o) begin
        s1_vld_q <= s_axis_tvalid_i;
      end
      if (!s2_vld_q || s2_leave) begin
        s2_vld_q <= s1_vld_q;
      end
      if (s1_leave) begin
        // Shift each row left, bring in the new column.
        win_q[0] <= win_q[1];
        win_q[1] <= win_q[2];
        win_q[2] <= above2;
        win_q[3] <= win_q[4];
        win_q[4] <= win_q[5];
        win_q[5] <= above;
        win_q[6] <= win_q[7];
        win_q[7] <= win_q[8];
        win_q[8] <= s1_pix_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_pix_q <= s_axis_tdata_i;
      s1_col_q <= in_col_q;
      s1_ctl_q <= acc_ctl;
    end
    if (s1_leave) begin
      s2_ctl_q <= s1_ctl_q;
    end
  end

  sem_edge_pipe u_edge_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s2_vld_q),
    .in_ready_o  (pipe_ready),
    .ctl_i       (s2_ctl_q),
    .win_i       (win_q),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .edge_o      (m_axis_tdata_o),
    .ctl_o       (out_ctl)
  );

  assign m_axis_tuser_o = out_ctl.valid;
  assign m_axis_tlast_o = out_ctl.last;

endmodule

`default_nettype wire

// File: src/sem_checker.sv
`default_nettype none
`include "sobel_edge_magnitude_stream_unit_assert.svh"

module sem_checker (
  input wire                           clk_i,
  input wire                           rst_ni,
  input wire                           s_axis_tready_o,
  input wire                           m_axis_tvalid_o,
  input wire                           m_axis_tready_i,
  input wire  [sem_pkg::PIX_W-1:0]     m_axis_tdata_o,
  input wire                           m_axis_tuser_o,
  input wire                           m_axis_tlast_o
);

  // Hold a stalled result beat.
  `SEM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o), "stalled result beat changed")

  // Frame end only on a real pixel.
  `SEM_ASSERT_IMPL(a_last_real, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tlast_o, m_axis_tuser_o, "frame end flagged during start-up fill")

  // Start-up fill results carry zero.
  `SEM_ASSERT_IMPL(a_fill_zero, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tuser_o, m_axis_tdata_o == '0, "nonzero edge during start-up fill")

  // Back-pressure only when a result is waiting.
  `SEM_ASSERT_IMPL(a_bp_cause, clk_i, rst_ni, !s_axis_tready_o, m_axis_tvalid_o && !m_axis_tready_i, "input stalled without a waiting result")

endmodule

bind sobel_edge_magnitude_stream_unit sem_checker u_sem_checker (.*);

`default_nettype wire

// File: verif/tb_sobel_edge_magnitude_stream_unit.sv
module tb_sobel_edge_magnitude_stream_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any beat on any channel before the run is declared hung.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // Long receiver hold-off used to fill the pipeline and stall the input.
  localparam int unsigned HOLD_CYCLES    = 300;
  // Settle time after the last result; the pipeline is four stages deep.
  localparam int unsigned DRAIN_SLACK    = 8;
  localparam int unsigned SHOW_LIMIT     = 10;

  typedef enum {
    PACE_FULL,
    PACE_SENDER_IDLE,
    PACE_RECEIVER_STALL,
    PACE_BOTH
  } pace_e;

  typedef enum {
    CONTENT_NOISE,
    CONTENT_SMOOTH,
    CONTENT_BILEVEL
  } content_e;

  // One result beat: edge value, real-pixel flag, end-of-frame flag.
  typedef struct packed {
    sem_pkg::sem_pix_t edge_val;
    logic              valid;
    logic              last;
  } edge_beat_t;

  // Edge-map scoreboard: mirrors the line stores, the 3x3 window and both
  // raster counters, and queues the result each accepted pixel must produce.
  class edge_map_checker;
    sem_pkg::sem_pix_t         row_above  [sem_pkg::DEF_MAX_WIDTH];
    sem_pkg::sem_pix_t         row_above2 [sem_pkg::DEF_MAX_WIDTH];
    sem_pkg::sem_pix_t         win        [sem_pkg::WIN_N];
    int unsigned               in_col, in_row, out_col, out_row, fill_cnt;
    bit                        primed;
    logic [sem_pkg::CFG_W-1:0] width_reg, height_reg;
    edge_beat_t                pending_edges[$];
    int unsigned               mismatch_count;

    function new();
      foreach (row_above[i]) row_above[i] = '0;
      foreach (row_above2[i]) row_above2[i] = '0;
      foreach (win[i]) win[i] = '0;
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
      fill_cnt = 0;
      primed = 1'b0;
      width_reg = sem_pkg::CFG_W'(sem_pkg::RESET_WIDTH);
      height_reg = sem_pkg::CFG_W'(sem_pkg::RESET_HEIGHT);
      mismatch_count = 0;
    endfunction

    // Zero acts as one, anything above the maximum acts as the maximum.
    function int unsigned span_of(logic [sem_pkg::CFG_W-1:0] v, int unsigned top);
      if (v == '0) return 1;
      if (v > top) return top;
      return v;
    endfunction

    function void set_register(sem_pkg::sem_reg_e idx, logic [sem_pkg::CFG_W-1:0] val);
      case (idx)
        sem_pkg::REG_FRAME_WIDTH:  width_reg = val;
        sem_pkg::REG_FRAME_HEIGHT: height_reg = val;
        default: ;
      endcase
    endfunction

    // Step a raster position; a counter beyond a shrunk size wraps at once.
    function void step_pos(inout int unsigned col, inout int unsigned row,
                           input int unsigned w, input int unsigned h);
      col++;
      if (col >= w) begin
        col = 0;
        row++;
        if (row >= h) row = 0;
      end
    endfunction

    function void take_pixel(sem_pkg::sem_pix_t pix);
      int unsigned       w, h, c;
      sem_pkg::sem_pix_t above, above2;
      int                gx, gy, mag;
      edge_beat_t        res;
      w = span_of(width_reg, sem_pkg::DEF_MAX_WIDTH);
      h = span_of(height_reg, sem_pkg::DEF_MAX_HEIGHT);
      c = in_col;
      // Shift the column of this pixel down through both line stores.
      above = row_above[c];
      above2 = row_above2[c];
      row_above2[c] = above;
      row_above[c] = pix;
      for (int r = 0; r < 3; r++) begin
        win[r*3] = win[r*3+1];
        win[r*3+1] = win[r*3+2];
      end
      win[2] = above2;
      win[5] = above;
      win[8] = pix;
      res = '0;
      if (!primed) begin
        // Start-up fill: result stays zero and the output position holds.
        fill_cnt++;
        if (fill_cnt >= w + 1) primed = 1'b1;
      end else begin
        res.valid = 1'b1;
        if (out_col >= 1 && out_col + 1 < w && out_row >= 1 && out_row + 1 < h) begin
          gx = (int'(win[2]) - int'(win[0])) + 2 * (int'(win[5]) - int'(win[3]))
             + (int'(win[8]) - int'(win[6]));
          gy = (int'(win[6]) - int'(win[0])) + 2 * (int'(win[7]) - int'(win[1]))
             + (int'(win[8]) - int'(win[2]));
          if (gx < 0) gx = -gx;
          if (gy < 0) gy = -gy;
          mag = (gx + gy) >> sem_pkg::MAG_SHIFT;
          if (mag > sem_pkg::PIX_MAX) mag = sem_pkg::PIX_MAX;
          res.edge_val = sem_pkg::sem_pix_t'(mag);
        end
        res.last = (out_col == w - 1) && (out_row == h - 1);
        step_pos(out_col, out_row, w, h);
      end
      step_pos(in_col, in_row, w, h);
      pending_edges.push_back(res);
    endfunction

    function void match_edge(sem_pkg::sem_pix_t data, logic user, logic last);
      edge_beat_t want;
      if (pending_edges.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= SHOW_LIMIT)
          $display("%0t: edge beat with nothing pending: data %0d user %b last %b",
                   $realtime, data, user, last);
        return;
      end
      want = pending_edges.pop_front();
      if (data !== want.edge_val || user !== want.valid || last !== want.last) begin
        mismatch_count++;
        if (mismatch_count <= SHOW_LIMIT)
          $display("%0t: edge beat mismatch: expected data %0d user %b last %b, got data %0d user %b last %b",
                   $realtime, want.edge_val, want.valid, want.last, data, user, last);
      end
    endfunction
  endclass

  logic                      clk        = 1'b0;
  logic                      rst_n      = 1'b0;
  logic                      s_tvalid   = 1'b0;
  logic                      s_tready;
  sem_pkg::sem_pix_t         s_tdata    = '0;
  logic                      m_tvalid;
  logic                      m_tready   = 1'b0;
  sem_pkg::sem_pix_t         m_tdata;
  logic                      m_tuser;
  logic                      m_tlast;
  logic                      cfg_valid  = 1'b0;
  logic                      cfg_ready;
  sem_pkg::sem_reg_e         cfg_index  = sem_pkg::REG_FRAME_WIDTH;
  logic [sem_pkg::CFG_W-1:0] cfg_data   = '0;

  pace_e            pace       = PACE_FULL;
  int unsigned      hold_asked = 0;
  int unsigned      hold_done  = 0;
  int unsigned      hold_left  = 0;
  edge_map_checker  board;

  sobel_edge_magnitude_stream_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // [7:0] pixel_in
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),   // [7:0] edge_out
    .m_axis_tuser_o  (m_tuser),   // [0] out_valid
    .m_axis_tlast_o  (m_tlast),   // frame_last
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  // 4 ns clock: 2 ns low, 2 ns high.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Sample every handshake at the rising edge: register writes first so the
  // predictor sees the new size before the next pixel beat.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) board.set_register(cfg_index, cfg_data);
      if (s_tvalid && s_tready) board.take_pixel(s_tdata);
      if (m_tvalid && m_tready) board.match_edge(m_tdata, m_tuser, m_tlast);
    end
  end

  // Result receiver: drive tready at the falling edge. A hold-off request
  // from the stimulus drops tready for a long stretch counted here.
  always @(negedge clk) begin
    if (hold_asked != hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = hold_asked;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= ((pace == PACE_RECEIVER_STALL) ? 80 :
                                          (pace == PACE_BOTH) ? 27 : 0));
    end
  end

  // Offer one pixel beat, with random gaps ahead of it; return at the falling
  // edge after the beat was taken, with nothing driven yet in that step.
  task automatic send_pixel(input sem_pkg::sem_pix_t pix);
    int unsigned gap_pct;
    gap_pct = (pace == PACE_SENDER_IDLE) ? 80 : (pace == PACE_BOTH) ? 27 : 0;
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= pix;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stream pixels of one content kind: white noise, a slow random walk for
  // weak edges, or hard black/white for strong ones.
  task automatic stream_pixels(input int unsigned count, input content_e kind);
    sem_pkg::sem_pix_t pix;
    int                level;
    level = $urandom_range(255);
    for (int unsigned n = 0; n < count; n++) begin
      case (kind)
        CONTENT_SMOOTH: begin
          level = level + $urandom_range(8) - 4;
          if (level < 0) level = 0;
          if (level > sem_pkg::PIX_MAX) level = sem_pkg::PIX_MAX;
          pix = sem_pkg::sem_pix_t'(level);
        end
        CONTENT_BILEVEL: pix = $urandom_range(1) ? sem_pkg::sem_pix_t'(sem_pkg::PIX_MAX) : '0;
        default:         pix = sem_pkg::sem_pix_t'($urandom);
      endcase
      send_pixel(pix);
    end
  endtask

  // Drop tvalid and hold until every queued result has come out, then let
  // the pipeline settle. Enter and leave at a falling edge.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (board.pending_edges.size() != 0) @(negedge clk);
    repeat (DRAIN_SLACK) @(negedge clk);
  endtask

  task automatic put_reg(input sem_pkg::sem_reg_e idx,
                         input logic [sem_pkg::CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_frame(input logic [sem_pkg::CFG_W-1:0] w,
                           input logic [sem_pkg::CFG_W-1:0] h);
    put_reg(sem_pkg::REG_FRAME_WIDTH, w);
    put_reg(sem_pkg::REG_FRAME_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  // Drain, resize the frame while idle, then stream under a new pace.
  task automatic run_phase(input logic [sem_pkg::CFG_W-1:0] w,
                           input logic [sem_pkg::CFG_W-1:0] h,
                           input int unsigned count, input pace_e p, input content_e kind);
    wait_drained();
    pace <= p;
    set_frame(w, h);
    stream_pixels(count, kind);
  endtask

  initial begin : stimulus
    sem_pkg::sem_pix_t corner_cases [27];
    corner_cases = '{8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd255,
                     8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
                     8'd0,   8'd0,   8'd255, 8'd0,   8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
    board = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset size 64x64: prime the pipeline, fill both line stores across the
    // row and reach the first interior pixels of row 1.
    stream_pixels(140, CONTENT_NOISE);

    // Width above the maximum acts as full width; two rows keep every result
    // on the border, and the few columns visited were all written above.
    run_phase(sem_pkg::CFG_W'(11'h7FF), sem_pkg::CFG_W'(2), 20, PACE_BOTH, CONTENT_NOISE);

    // Smallest frame with an interior: vertical step, horizontal step, corner.
    wait_drained();
    pace <= PACE_FULL;
    set_frame(sem_pkg::CFG_W'(3), sem_pkg::CFG_W'(3));
    foreach (corner_cases[i]) send_pixel(corner_cases[i]);

    // Zero sizes act as 1x1: every real result closes a frame.
    run_phase('0, '0, 16, PACE_BOTH, CONTENT_NOISE);
    // Width 1: a line store read meets the write of the same column.
    run_phase(sem_pkg::CFG_W'(1), sem_pkg::CFG_W'(5), 30, PACE_RECEIVER_STALL, CONTENT_BILEVEL);
    // Narrow and short: all border.
    run_phase(sem_pkg::CFG_W'(2), sem_pkg::CFG_W'(2), 16, PACE_SENDER_IDLE, CONTENT_NOISE);

    // Narrowest interior, height above the maximum acts as full height.
    run_phase(sem_pkg::CFG_W'(3), sem_pkg::CFG_W'(11'h7FF), 40, PACE_FULL, CONTENT_NOISE);

    // Long receiver hold-off: the pipeline fills and the input must stall.
    wait_drained();
    pace <= PACE_FULL;
    set_frame(sem_pkg::CFG_W'(8), sem_pkg::CFG_W'(6));
    hold_asked <= hold_asked + 1;
    stream_pixels(50, CONTENT_NOISE);

    // Sender pauses mid-stream until every result is out, then resumes.
    run_phase(sem_pkg::CFG_W'(5), sem_pkg::CFG_W'(4), 30, PACE_SENDER_IDLE, CONTENT_SMOOTH);
    wait_drained();
    stream_pixels(30, CONTENT_BILEVEL);

    // Random small frames, cycling through every pace.
    for (int ph = 0; ph < 8; ph++)
      run_phase(sem_pkg::CFG_W'($urandom_range(16, 2)), sem_pkg::CFG_W'($urandom_range(12, 2)),
                $urandom_range(18, 8), pace_e'(ph % 4),
                content_e'($urandom_range(2)));

    // Back to the reset size.
    run_phase(sem_pkg::CFG_W'(sem_pkg::RESET_WIDTH), sem_pkg::CFG_W'(sem_pkg::RESET_HEIGHT),
              30, PACE_BOTH, CONTENT_NOISE);

    wait_drained();
    if (board.mismatch_count == 0 && board.pending_edges.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: end the run when no channel moves a beat for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/sem_pkg.sv
src/sem_edge_pipe.sv
src/sobel_edge_magnitude_stream_unit.sv
src/sem_checker.sv
verif/tb_sobel_edge_magnitude_stream_unit.sv
